>>> hdl/ygnim_pkg.sv
// Shared types and constants of the Yee grid nearest index map.
`default_nettype none
package ygnim_pkg;

  localparam int ROW_W      = 33;
  localparam int SIZE_W     = 11;
  localparam int OFFS_W     = 30;
  localparam int MODE_W     = 2;
  localparam int COL_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;
  localparam int NUM_COMP   = 3;
  localparam int COMP_W     = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int MODE_SLAB  = 0;
  localparam int MODE_ANISO = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_YEE_X  = 3'd0,
    REG_YEE_Y  = 3'd1,
    REG_YEE_Z  = 3'd2,
    REG_DATA_X = 3'd3,
    REG_DATA_Y = 3'd4,
    REG_DATA_Z = 3'd5,
    REG_OFFS   = 3'd6,
    REG_MODE   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0] yee_x;
    logic [SIZE_W-1:0] yee_y;
    logic [SIZE_W-1:0] yee_z;
    logic [SIZE_W-1:0] data_x;
    logic [SIZE_W-1:0] data_y;
    logic [SIZE_W-1:0] data_z;
    logic [OFFS_W-1:0] offsets;
    logic [MODE_W-1:0] mode;
  } cfg_t;

  typedef struct packed {
    logic              zero_size;
    logic [SIZE_W-1:0] ix;
    logic [SIZE_W-1:0] iy;
    logic [SIZE_W-1:0] iz;
    logic [COMP_W-1:0] ic;
  } coord_t;

endpackage
`default_nettype wire

>>> hdl/ygnim_in_if.sv
// Item channels: row indices in, column results out.
`default_nettype none
interface ygnim_in_if import ygnim_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_index;
  modport source (output valid, output row_index, input ready);
  modport sink (input valid, input row_index, output ready);
endinterface

interface ygnim_out_if import ygnim_pkg::*;;
  logic             valid;
  logic             ready;
  logic             has_entry;
  logic [COL_W-1:0] column_index;
  modport source (output valid, output has_entry, output column_index, input ready);
  modport sink (input valid, input has_entry, input column_index, output ready);
endinterface
`default_nettype wire

>>> hdl/ygnim_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
`default_nettype none
module ygnim_div #(
  parameter int DW = 33,
  parameter int VW = 11,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder,
  output logic [SW-1:0] side_out
);

  logic [DW:0]   vld;
  logic [DW-1:0] wrd [DW+1];
  logic [VW-1:0] rem [DW+1];
  logic [SW-1:0] sde [DW+1];

  assign vld[0] = in_valid;
  assign wrd[0] = dividend;
  assign rem[0] = '0;
  assign sde[0] = side_in;

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [VW:0]   trial;
    logic          ge;
    logic          valid_r;
    logic [DW-1:0] wrd_r;
    logic [VW-1:0] rem_r;
    logic [SW-1:0] sde_r;

    assign trial = {rem[k], wrd[k][DW-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r <= 1'b0;
      end else if (en) begin
        valid_r <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= ge ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
        wrd_r <= {wrd[k][DW-2:0], ge};
        sde_r <= sde[k];
      end
    end

    assign vld[k+1] = valid_r;
    assign wrd[k+1] = wrd_r;
    assign rem[k+1] = rem_r;
    assign sde[k+1] = sde_r;
  end

  assign out_valid = vld[DW];
  assign quotient  = wrd[DW];
  assign remainder = rem[DW];
  assign side_out  = sde[DW];

endmodule
`default_nettype wire

>>> hdl/ygnim_front.sv
// Front part: splits each row into z, y and x by chained dividers and reduces the rest modulo three.
`default_nettype none
module ygnim_front import ygnim_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [ROW_W-1:0] row_index,
  input  cfg_t             cfg,
  output logic             out_valid,
  output coord_t           out_coord
);

  localparam int PAD_W  = 40;
  localparam int BSUM_W = 11;

  logic              zf;
  logic              v1, v2, v3;
  logic [ROW_W-1:0]  q1, q2, q3;
  logic [SIZE_W-1:0] iz, iy, ix;
  logic              s1;
  logic [SIZE_W:0]   s2;
  logic [2*SIZE_W:0] s3;
  logic [PAD_W-1:0]  q3_pad;
  logic [BSUM_W-1:0] bsum;
  logic [4:0]        dsum;
  logic [2:0]        fold;
  logic [COMP_W-1:0] ic;
  logic              m1_valid_r, m2_valid_r;
  logic [BSUM_W-1:0] m1_sum_r;
  logic [3*SIZE_W:0] m1_side_r, m2_side_r;
  logic [COMP_W-1:0] m2_ic_r;

  assign zf = (cfg.yee_x == '0) || (cfg.yee_y == '0) || (cfg.yee_z == '0);

  ygnim_div #(.DW(ROW_W), .VW(SIZE_W), .SW(1)) u_div_z (
    .clk, .rst_n, .en, .in_valid, .dividend(row_index), .divisor(cfg.yee_z),
    .side_in(zf), .out_valid(v1), .quotient(q1), .remainder(iz), .side_out(s1)
  );

  ygnim_div #(.DW(ROW_W), .VW(SIZE_W), .SW(SIZE_W+1)) u_div_y (
    .clk, .rst_n, .en, .in_valid(v1), .dividend(q1), .divisor(cfg.yee_y),
    .side_in({s1, iz}), .out_valid(v2), .quotient(q2), .remainder(iy), .side_out(s2)
  );

  ygnim_div #(.DW(ROW_W), .VW(SIZE_W), .SW(2*SIZE_W+1)) u_div_x (
    .clk, .rst_n, .en, .in_valid(v2), .dividend(q2), .divisor(cfg.yee_x),
    .side_in({s2, iy}), .out_valid(v3), .quotient(q3), .remainder(ix), .side_out(s3)
  );

  // Powers of 256 and of 4 are all one modulo three, so digit sums keep the remainder.
  assign q3_pad = {{(PAD_W-ROW_W){1'b0}}, q3};
  assign bsum   = (BSUM_W'(q3_pad[7:0]) + BSUM_W'(q3_pad[15:8]))
                + (BSUM_W'(q3_pad[23:16]) + BSUM_W'(q3_pad[31:24]))
                + BSUM_W'(q3_pad[39:32]);

  assign dsum = (5'(m1_sum_r[1:0]) + 5'(m1_sum_r[3:2]))
              + (5'(m1_sum_r[5:4]) + 5'(m1_sum_r[7:6]))
              + (5'(m1_sum_r[9:8]) + 5'(m1_sum_r[10]));
  assign fold = (3'(dsum[1:0]) + 3'(dsum[3:2])) + 3'(dsum[4]);

  always_comb begin
    case (fold)
      3'd1, 3'd4, 3'd7: ic = 2'd1;
      3'd2, 3'd5:       ic = 2'd2;
      default:          ic = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
      m2_valid_r <= 1'b0;
    end else if (en) begin
      m1_valid_r <= v3;
      m2_valid_r <= m1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_sum_r  <= bsum;
      m1_side_r <= {s3, ix};
      m2_ic_r   <= ic;
      m2_side_r <= m1_side_r;
    end
  end

  assign out_valid           = m2_valid_r;
  assign out_coord.zero_size = m2_side_r[3*SIZE_W];
  assign out_coord.iz        = m2_side_r[3*SIZE_W-1:2*SIZE_W];
  assign out_coord.iy        = m2_side_r[2*SIZE_W-1:SIZE_W];
  assign out_coord.ix        = m2_side_r[SIZE_W-1:0];
  assign out_coord.ic        = m2_ic_r;

endmodule
`default_nettype wire

>>> hdl/ygnim_fifo.sv
// Short queue between the front and back parts.
`default_nettype none
module ygnim_fifo import ygnim_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  coord_t push_data,
  input  logic   pop,
  output coord_t pop_data,
  output logic   full,
  output logic   not_empty
);

  coord_t                mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_r, rd_r;
  logic [FIFO_PTR_W:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign pop_data  = mem_r[rd_r];
  assign full      = cnt_r == (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign not_empty = cnt_r != '0;

endmodule
`default_nettype wire

>>> hdl/ygnim_back.sv
// Back part: box check, offset removal and column arithmetic.
`default_nettype none
module ygnim_back import ygnim_pkg::*; #(
  parameter int DIM_BITS = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             item_valid,
  input  coord_t           item,
  output logic             pop,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             has_entry,
  output logic [COL_W-1:0] column_index
);

  localparam int OW = 3 * DIM_BITS;
  localparam int CW = ((DIM_BITS > SIZE_W) ? DIM_BITS : SIZE_W) + 1;

  logic [OW-1:0]       offs_all;
  logic [DIM_BITS-1:0] off_x, off_y, off_z;
  logic [CW-1:0]       dx, dy, dz;
  logic                ok_x, ok_y, ok_z, en;

  logic                a_valid_r, a_hit_r;
  logic [SIZE_W-1:0]   a_xd_r, a_yd_r, a_zd_r;
  logic [COMP_W-1:0]   a_ic_r;
  logic                b_valid_r, b_hit_r;
  logic [2*SIZE_W-1:0] b_id_r;
  logic [SIZE_W-1:0]   b_zd_r;
  logic [COMP_W-1:0]   b_ic_r;
  logic                c_valid_r, c_hit_r;
  logic [COL_W-1:0]    c_id_r;
  logic [COMP_W-1:0]   c_ic_r;
  logic [3*SIZE_W:0]   id_full;
  logic [2*SIZE_W-1:0] volxy_r;
  logic [3*SIZE_W:0]   vol_full;
  logic [COL_W-1:0]    vol_r, icvol, col;
  logic                out_valid_r, has_entry_r;
  logic [COL_W-1:0]    column_r;

  if (OW > OFFS_W) begin : g_offs_wide
    assign offs_all = {{(OW-OFFS_W){1'b0}}, cfg.offsets};
  end else begin : g_offs_narrow
    assign offs_all = cfg.offsets[OW-1:0];
  end

  assign off_x = offs_all[DIM_BITS-1:0];
  assign off_y = offs_all[2*DIM_BITS-1:DIM_BITS];
  assign off_z = offs_all[3*DIM_BITS-1:2*DIM_BITS];

  assign dx   = CW'(item.ix) - CW'(off_x);
  assign dy   = CW'(item.iy) - CW'(off_y);
  assign dz   = CW'(item.iz) - CW'(off_z);
  assign ok_x = !dx[CW-1] && (dx < CW'(cfg.data_x));
  assign ok_y = !dy[CW-1] && (dy < CW'(cfg.data_y));
  assign ok_z = !dz[CW-1] && (dz < CW'(cfg.data_z));

  assign en  = !out_valid_r || out_ready;
  assign pop = en && item_valid;

  assign id_full  = (3*SIZE_W+1)'(b_id_r * cfg.data_z) + (3*SIZE_W+1)'(b_zd_r);
  assign vol_full = (3*SIZE_W+1)'(volxy_r * cfg.data_z);

  always_comb begin
    case (c_ic_r)
      2'd1:    icvol = vol_r;
      2'd2:    icvol = {vol_r[COL_W-2:0], 1'b0};
      default: icvol = '0;
    endcase
  end

  assign col = c_id_r + (cfg.mode[MODE_ANISO] ? icvol : '0);

  always_ff @(posedge clk) begin
    volxy_r <= cfg.data_x * cfg.data_y;
    vol_r   <= cfg.mode[MODE_SLAB] ? COL_W'(volxy_r) : vol_full[COL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r   <= item_valid;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_hit_r     <= !item.zero_size && ok_x && ok_y && ok_z;
      a_xd_r      <= dx[SIZE_W-1:0];
      a_yd_r      <= dy[SIZE_W-1:0];
      a_zd_r      <= dz[SIZE_W-1:0];
      a_ic_r      <= item.ic;
      b_hit_r     <= a_hit_r;
      b_id_r      <= (2*SIZE_W)'(a_xd_r * cfg.data_y) + (2*SIZE_W)'(a_yd_r);
      b_zd_r      <= a_zd_r;
      b_ic_r      <= a_ic_r;
      c_hit_r     <= b_hit_r;
      c_id_r      <= cfg.mode[MODE_SLAB] ? COL_W'(b_id_r) : id_full[COL_W-1:0];
      c_ic_r      <= b_ic_r;
      has_entry_r <= c_hit_r;
      column_r    <= c_hit_r ? col : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign has_entry    = has_entry_r;
  assign column_index = column_r;

endmodule
`default_nettype wire

>>> hdl/yee_grid_nearest_index_map.sv
// Top level of the Yee grid nearest index map.
// The block maps each row index of a six-part Yee field vector to the one data
// column that feeds it, or reports that the row has no entry.
// Items enter on in_ch (valid/ready, row_index) and leave on out_ch
// (valid/ready, has_entry, column_index), exactly one result per item, in order.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while the block is idle, which the block does not enforce.
// A write takes effect at once and has no read-back. An item passes 106
// registers, the first loaded at the accepting edge: 99 divider stages (33 per
// divide by the z, y and x extents), two stages reducing the rest modulo three,
// the queue and four back stages ending in the output register.
// Throughput is one item per cycle while the queue is not full, set by the
// one-bit-per-stage dividers. When the receiver stalls, the back part holds and
// the queue fills; once it is full the front part and in_ch.ready stall too.
// Reset empties the pipeline and queue and returns the configuration registers
// to their reset values.
`default_nettype none
module yee_grid_nearest_index_map import ygnim_pkg::*; #(
  parameter int DIM_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ygnim_in_if.sink              in_ch,
  ygnim_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg_r;
  logic   front_en, front_valid, fifo_full, fifo_ne, fifo_pop;
  coord_t front_coord, fifo_coord;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{yee_x: SIZE_W'(1), yee_y: SIZE_W'(1), yee_z: SIZE_W'(1),
                 data_x: SIZE_W'(1), data_y: SIZE_W'(1), data_z: SIZE_W'(1),
                 offsets: '0, mode: '0};
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_YEE_X:  cfg_r.yee_x   <= cfg_data[SIZE_W-1:0];
        REG_YEE_Y:  cfg_r.yee_y   <= cfg_data[SIZE_W-1:0];
        REG_YEE_Z:  cfg_r.yee_z   <= cfg_data[SIZE_W-1:0];
        REG_DATA_X: cfg_r.data_x  <= cfg_data[SIZE_W-1:0];
        REG_DATA_Y: cfg_r.data_y  <= cfg_data[SIZE_W-1:0];
        REG_DATA_Z: cfg_r.data_z  <= cfg_data[SIZE_W-1:0];
        REG_OFFS:   cfg_r.offsets <= cfg_data[OFFS_W-1:0];
        REG_MODE:   cfg_r.mode    <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign front_en    = !fifo_full;
  assign in_ch.ready = front_en;

  ygnim_front u_front (
    .clk, .rst_n, .en(front_en), .in_valid(in_ch.valid),
    .row_index(in_ch.row_index), .cfg(cfg_r),
    .out_valid(front_valid), .out_coord(front_coord)
  );

  ygnim_fifo u_fifo (
    .clk, .rst_n, .push(front_valid && front_en), .push_data(front_coord),
    .pop(fifo_pop), .pop_data(fifo_coord), .full(fifo_full), .not_empty(fifo_ne)
  );

  ygnim_back #(.DIM_BITS(DIM_BITS)) u_back (
    .clk, .rst_n, .cfg(cfg_r), .item_valid(fifo_ne), .item(fifo_coord),
    .pop(fifo_pop), .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .has_entry(out_ch.has_entry), .column_index(out_ch.column_index)
  );

endmodule
`default_nettype wire

>>> hdl/ygnim_checker.sv
// Port-level checks of the Yee grid nearest index map, bound to the top level.
`default_nettype none
module ygnim_checker import ygnim_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             has_entry,
  input logic [COL_W-1:0] column_index
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !has_entry) |-> (column_index == '0))
    else $error("empty row with non-zero column");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(has_entry) && $stable(column_index)))
    else $error("result changed while stalled");

endmodule

bind yee_grid_nearest_index_map ygnim_checker u_ygnim_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .has_entry(out_ch.has_entry),
  .column_index(out_ch.column_index)
);
`default_nettype wire

>>> bench/yee_grid_nearest_index_map_tb.sv
// Self-checking testbench of the Yee grid nearest index map, predicting each column.
`timescale 1ns / 1ps
`default_nettype none
module yee_grid_nearest_index_map_tb;
  import ygnim_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic             has_entry;
    logic [COL_W-1:0] column_index;
  } column_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ygnim_in_if in_ch ();
  ygnim_out_if out_ch ();

  yee_grid_nearest_index_map u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [SIZE_W-1:0] g_yee [3];
  logic [SIZE_W-1:0] g_data [3];
  logic [OFFS_W-1:0] g_offsets;
  logic [MODE_W-1:0] g_mode;

  column_t pending_columns[$];
  int error_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int stall_kind = 0;
  int stall_phase = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic column_t map_row(logic [ROW_W-1:0] row);
    column_t res;
    longint unsigned r, q, coord[3], vol, id, ic;
    longint signed d[3];
    res = '0;
    if (g_yee[0] == 0 || g_yee[1] == 0 || g_yee[2] == 0) return res;
    r = row;
    coord[2] = r % g_yee[2];
    q = r / g_yee[2];
    coord[1] = q % g_yee[1];
    q = q / g_yee[1];
    coord[0] = q % g_yee[0];
    q = q / g_yee[0];
    ic = q % NUM_COMP;
    for (int a = 0; a < 3; a++) begin
      d[a] = longint'(coord[a]) - longint'(g_offsets[a*10 +: 10]);
      if (d[a] < 0 || longint'(d[a]) >= longint'(g_data[a])) return res;
    end
    id = longint'(d[0]) * g_data[1] + d[1];
    vol = longint'(g_data[0]) * g_data[1];
    if (!g_mode[MODE_SLAB]) begin
      id = id * g_data[2] + d[2];
      vol = vol * g_data[2];
    end
    if (g_mode[MODE_ANISO]) id = id + ic * vol;
    res.has_entry = 1'b1;
    res.column_index = id[COL_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_YEE_X:  g_yee[0] = value[SIZE_W-1:0];
      REG_YEE_Y:  g_yee[1] = value[SIZE_W-1:0];
      REG_YEE_Z:  g_yee[2] = value[SIZE_W-1:0];
      REG_DATA_X: g_data[0] = value[SIZE_W-1:0];
      REG_DATA_Y: g_data[1] = value[SIZE_W-1:0];
      REG_DATA_Z: g_data[2] = value[SIZE_W-1:0];
      REG_OFFS:   g_offsets = value[OFFS_W-1:0];
      REG_MODE:   g_mode = value[MODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    burst_left = 0;
    while (pending_columns.size() != 0) @(negedge clk);
  endtask

  task automatic load_grid(int yx, int yy, int yz, int dx, int dy, int dz,
                           int ox, int oy, int oz, int mode);
    wait_idle();
    write_reg(REG_YEE_X, CFG_DATA_W'(yx));
    write_reg(REG_YEE_Y, CFG_DATA_W'(yy));
    write_reg(REG_YEE_Z, CFG_DATA_W'(yz));
    write_reg(REG_DATA_X, CFG_DATA_W'(dx));
    write_reg(REG_DATA_Y, CFG_DATA_W'(dy));
    write_reg(REG_DATA_Z, CFG_DATA_W'(dz));
    write_reg(REG_OFFS, {oz[9:0], oy[9:0], ox[9:0]});
    write_reg(REG_MODE, CFG_DATA_W'(mode));
  endtask

  task automatic send_row(logic [ROW_W-1:0] row);
    @(negedge clk);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.row_index = row;
    #1;
    while (!in_ch.ready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    pending_columns.push_back(map_row(row));
  endtask

  function automatic logic [ROW_W-1:0] pick_row();
    longint unsigned span, r;
    span = 6 * longint'(g_yee[0]) * g_yee[1] * g_yee[2];
    r = {$urandom, $urandom};
    if (span != 0 && $urandom_range(0, 9) < 8) r = r % span;
    return r[ROW_W-1:0];
  endfunction

  always @(negedge clk) begin
    if (cycle_count % 150 == 0) stall_kind = $urandom_range(0, 3);
    stall_phase++;
    case (stall_kind)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= (stall_phase % 3) != 0;
      2: out_ch.ready <= 1'($urandom_range(0, 1));
      default: out_ch.ready <= (stall_phase % 40) < 30;
    endcase
  end

  always @(posedge clk) begin
    column_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_columns.size() == 0) begin
        report_mismatch("unexpected item", longint'(out_ch.column_index), 0);
      end else begin
        want = pending_columns.pop_front();
        if (out_ch.has_entry !== want.has_entry)
          report_mismatch("has_entry", longint'(out_ch.has_entry),
                          longint'(want.has_entry));
        if (out_ch.column_index !== want.column_index)
          report_mismatch("column_index", longint'(out_ch.column_index),
                          longint'(want.column_index));
      end
    end
  end

  task automatic test_reset_defaults();
    send_row('0);
    send_row(33'd1);
    send_row(33'd3);
    send_row(33'h17FFFFFFF);
    send_row('1);
  endtask

  task automatic test_directed_extremes();
    load_grid(4, 3, 5, 2, 2, 3, 1, 1, 2, 0);
    for (int i = 0; i < 6; i++) send_row($urandom_range(0, 359));
    load_grid(4, 3, 5, 2, 2, 3, 1, 1, 2, 3);
    send_row(33'd7);
    send_row(33'd187);
    load_grid(0, 5, 5, 4, 4, 4, 0, 0, 0, 2);
    send_row(33'd9);
    load_grid(4, 4, 4, 0, 4, 4, 0, 0, 0, 0);
    send_row(33'd9);
    load_grid(1024, 1024, 1024, 1024, 1024, 1024, 0, 0, 0, 2);
    send_row(33'h17FFFFFFF);
    send_row(33'h1FFFFFFFF);
    send_row(33'h0FFFFFFFF);
    load_grid(2047, 2047, 2047, 2047, 2047, 2047, 1023, 1023, 1023, 1);
    send_row('1);
    send_row(33'h155555555);
    send_row(33'h0AAAAAAAA);
  endtask

  task automatic test_random_grids();
    for (int p = 0; p < 12; p++) begin
      if (p % 5 == 4)
        load_grid($urandom_range(512, 2047), $urandom_range(512, 2047),
                  $urandom_range(512, 2047), $urandom_range(0, 2047),
                  $urandom_range(0, 2047), $urandom_range(0, 2047),
                  $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom_range(0, 3));
      else
        load_grid($urandom_range(1, 9), $urandom_range(1, 9), $urandom_range(1, 9),
                  $urandom_range(1, 9), $urandom_range(1, 9), $urandom_range(1, 9),
                  $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                  $urandom_range(0, 3));
      for (int i = 0; i < 128; i++) send_row(pick_row());
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.row_index = '0;
    g_yee = '{1, 1, 1};
    g_data = '{1, 1, 1};
    g_offsets = '0;
    g_mode = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_directed_extremes();
    test_random_grids();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_columns.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
